FILE: rtl/sps_pkg.sv
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, register codes and helpers for the strided prefix-sum core.
// ----------------------------------------------------------------------------
package sps_pkg;

  // Default depth of the partial-sum buffer (largest supported stride)
  localparam int unsigned MaxStrideDef = 1024;

  // Field widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned SumW    = 32;
  localparam int unsigned LenW    = 16;
  localparam int unsigned StrideW = 11;
  // Stride arithmetic width, wide enough for the largest buffer depth (65536)
  localparam int unsigned StrideCW = 17;

  // Configuration port
  localparam int unsigned ApbAddrW = 3;
  localparam int unsigned ApbDataW = 32;

  // Register index codes, decoded from paddr[2]
  localparam logic REG_AXIS_LENGTH  = 1'b0;
  localparam logic REG_INNER_STRIDE = 1'b1;

  // Configuration register contents
  typedef struct packed {
    logic [LenW-1:0]    axis_length;
    logic [StrideW-1:0] inner_stride;
  } sps_cfg_t;

  // Per-beat position flags from the address generator
  typedef struct packed {
    logic first_row;  // row 0 of the axis: no stored partial sum is used
    logic last;       // last position of the last row
  } sps_flags_t;

  // Zero length acts as one
  function automatic logic [LenW-1:0] eff_length(input logic [LenW-1:0] len);
    return (len == '0) ? LenW'(1) : len;
  endfunction

  // Zero stride acts as one, large strides clamp to the buffer depth
  function automatic logic [StrideCW-1:0] eff_stride(input logic [StrideW-1:0]  s,
                                                      input logic [StrideCW-1:0] mx);
    logic [StrideCW-1:0] e;
    e = (s == '0) ? StrideCW'(1) : StrideCW'(s);
    return (e > mx) ? mx : e;
  endfunction

endpackage

FILE: rtl/sps_cfg_regs.sv
// ----------------------------------------------------------------------------
// sps_cfg_regs
// APB register file holding axis length and inner stride.
// ----------------------------------------------------------------------------
module sps_cfg_regs import sps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output sps_cfg_t            cfg_o,
  output logic                restart_o
);

  sps_cfg_t cfg_q, cfg_d;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register write decode; any write restarts the position counters
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_AXIS_LENGTH:  cfg_d.axis_length  = pwdata[LenW-1:0];
        REG_INNER_STRIDE: cfg_d.inner_stride = pwdata[StrideW-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis_length  <= LenW'(1);
      cfg_q.inner_stride <= StrideW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back mux
  always_comb begin
    unique case (paddr[2])
      REG_AXIS_LENGTH:  prdata = ApbDataW'(cfg_q.axis_length);
      REG_INNER_STRIDE: prdata = ApbDataW'(cfg_q.inner_stride);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o     = cfg_q;
  assign restart_o = wr_en;

endmodule

FILE: rtl/sps_addr_gen.sv
// ----------------------------------------------------------------------------
// sps_addr_gen
// Inner-position and row counters; wrap at stride and axis length.
// ----------------------------------------------------------------------------
module sps_addr_gen import sps_pkg::*; #(
  parameter int unsigned MAX_STRIDE = MaxStrideDef,
  localparam int unsigned PosW = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sps_cfg_t        cfg_i,
  input  logic            restart_i,
  input  logic            advance_i,
  output logic [PosW-1:0] pos_o,
  output sps_flags_t      flags_o
);

  logic [PosW-1:0]     pos_q, pos_d;
  logic [LenW-1:0]     row_q, row_d;
  logic [StrideCW-1:0] stride_eff;
  logic [LenW-1:0]     len_eff;
  logic                row_end;
  logic                last_row;

  assign stride_eff = eff_stride(cfg_i.inner_stride, StrideCW'(MAX_STRIDE));
  assign len_eff    = eff_length(cfg_i.axis_length);

  // End-of-row and end-of-slice detection
  assign row_end  = (StrideCW'(pos_q) + StrideCW'(1)) == stride_eff;
  assign last_row = ({1'b0, row_q} + (LenW+1)'(1)) == {1'b0, len_eff};

  always_comb begin
    pos_d = pos_q;
    row_d = row_q;
    if (restart_i) begin
      pos_d = '0;
      row_d = '0;
    end else if (advance_i) begin
      if (row_end) begin
        pos_d = '0;
        row_d = last_row ? '0 : row_q + LenW'(1);
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      row_q <= '0;
    end else begin
      pos_q <= pos_d;
      row_q <= row_d;
    end
  end

  assign pos_o             = pos_q;
  assign flags_o.first_row = (row_q == '0);
  assign flags_o.last      = row_end && last_row;

endmodule

FILE: rtl/sps_accum.sv
// ----------------------------------------------------------------------------
// sps_accum
// Input stage, partial-sum buffer and saturating adder.
// ----------------------------------------------------------------------------
module sps_accum import sps_pkg::*; #(
  parameter int unsigned MAX_STRIDE = MaxStrideDef,
  localparam int unsigned PosW = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_fire_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic [PosW-1:0]           pos_i,
  input  sps_flags_t                flags_i,
  input  logic                      advance_i,
  output logic                      valid_o,
  output logic signed [SumW-1:0]    sum_o,
  output logic                      last_o
);

  logic [SumW-1:0]             mem_q [MAX_STRIDE];
  logic [SumW-1:0]             rd_q;
  logic [SumW-1:0]             fwd_q;
  logic                        hit_q;
  logic                        valid_q;
  logic signed [SampleW-1:0]   sample_q;
  logic [PosW-1:0]             pos_q;
  sps_flags_t                  flags_q;
  logic signed [SumW-1:0]      operand;
  logic signed [SumW:0]        wide_sum;
  logic signed [SumW-1:0]      sum;
  logic                        wr_en;

  assign wr_en = valid_q && advance_i;

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_fire_i) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  // Stage payload, buffer read and forwarding of the sum written this edge
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      sample_q <= sample_i;
      pos_q    <= pos_i;
      flags_q  <= flags_i;
      rd_q     <= mem_q[pos_i];
      hit_q    <= wr_en && (pos_q == pos_i);
      fwd_q    <= sum;
    end
  end

  // Buffer write-back
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[pos_q] <= sum;
    end
  end

  // Saturating add; row 0 passes the sample through
  assign operand  = hit_q ? fwd_q : rd_q;
  assign wide_sum = (SumW+1)'(operand) + (SumW+1)'(sample_q);

  always_comb begin
    if (flags_q.first_row) begin
      sum = SumW'(sample_q);
    end else if (wide_sum[SumW] != wide_sum[SumW-1]) begin
      sum = wide_sum[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum = wide_sum[SumW-1:0];
    end
  end

  assign valid_o = valid_q;
  assign sum_o   = sum;
  assign last_o  = flags_q.last;

endmodule

FILE: rtl/strided_axis_prefix_sum_core.sv
// ----------------------------------------------------------------------------
// strided_axis_prefix_sum_core
// Running sum of a row-major tensor stream along one strided axis.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one signed Q8.8 element each (sample_i, valid/ready).
//   Output beats carry the saturated Q24.8 running sum along the axis and
//   block_end_o, set on the last element of each outer slice.
//   axis_length and inner_stride are set over the APB port at offsets 0x0
//   and 0x4; any write restarts the pattern at row 0, position 0. Write them
//   only while no beat is in flight.
// Path: an accepted beat is registered in the input stage, with its buffer
//   read, then in the output register. Throughput: one beat per cycle
//   while out_ready_i is high, one buffer read and one write per beat;
//   a sum written at one edge is forwarded to the beat read at that edge.
// Reset: axis_length and inner_stride return to 1, counters to zero. The
//   partial-sum buffer is not cleared; row 0 always writes an entry before
//   a later row reads it.
// Stall: while out_ready_i is low the output holds; one more beat can sit in
//   the input stage before in_ready_o drops.
// ----------------------------------------------------------------------------
module strided_axis_prefix_sum_core import sps_pkg::*; #(
  parameter int unsigned MAX_STRIDE = MaxStrideDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // APB configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ApbAddrW-1:0]       paddr,
  input  logic [ApbDataW-1:0]       pwdata,
  output logic [ApbDataW-1:0]       prdata,
  output logic                      pready,
  // Input stream
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SampleW-1:0] sample_i,
  // Output stream
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SumW-1:0]    running_sum_o,
  output logic                      block_end_o
);

  localparam int unsigned PosW = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;

  sps_cfg_t               cfg;
  logic                   restart;
  logic [PosW-1:0]        pos;
  sps_flags_t             flags;
  logic                   in_fire;
  logic                   s1_valid;
  logic                   s1_adv;
  logic                   out_free;
  logic signed [SumW-1:0] s1_sum;
  logic                   s1_last;
  logic                   out_valid_q;
  logic signed [SumW-1:0] sum_q;
  logic                   last_q;

  sps_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  sps_addr_gen #(.MAX_STRIDE(MAX_STRIDE)) u_addr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .restart_i (restart),
    .advance_i (in_fire),
    .pos_o     (pos),
    .flags_o   (flags)
  );

  sps_accum #(.MAX_STRIDE(MAX_STRIDE)) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_fire_i (in_fire),
    .sample_i  (sample_i),
    .pos_i     (pos),
    .flags_i   (flags),
    .advance_i (s1_adv),
    .valid_o   (s1_valid),
    .sum_o     (s1_sum),
    .last_o    (s1_last)
  );

  // Handshake: stages move whenever the stage ahead is free or draining
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid && out_free;
  assign in_ready_o = !s1_valid || out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      sum_q  <= s1_sum;
      last_q <= s1_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign running_sum_o = sum_q;
  assign block_end_o   = last_q;

  // Checks

  // Inner position stays below the effective stride
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    StrideCW'(pos) < eff_stride(cfg.inner_stride, StrideCW'(MAX_STRIDE)))
    else $error("inner position out of range");

  // A register write restarts the pattern at row 0, position 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart |=> (pos == '0) && flags.first_row)
    else $error("pattern not restarted after register write");

  // A beat leaving the input stage lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("beat lost between stages");

  // An empty input stage never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid |-> in_ready_o)
    else $error("input blocked with empty stage");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the strided prefix-sum core. Samples stream in over
// valid/ready with random gaps on both sides; a scoreboard model predicts each
// running sum and slice-end flag as a beat is accepted, and the monitor checks
// the output beats against it in order. Registers are written and read back
// over APB between traffic phases.
// ----------------------------------------------------------------------------
module testbench;
  import sps_pkg::*;

  localparam int unsigned DepthMax = MaxStrideDef;
  localparam logic [ApbAddrW-1:0] AddrAxisLength  = {REG_AXIS_LENGTH, 2'b00};
  localparam logic [ApbAddrW-1:0] AddrInnerStride = {REG_INNER_STRIDE, 2'b00};
  localparam int unsigned LongHoldCycles = 300;

  typedef struct {
    logic signed [SumW-1:0] sum;
    logic                   last;
  } sum_beat_t;

  // DUT connections, all inputs known from time zero
  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [ApbAddrW-1:0]       paddr = '0;
  logic [ApbDataW-1:0]       pwdata = '0;
  logic [ApbDataW-1:0]       prdata;
  logic                      pready;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] sample_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic signed [SumW-1:0]    running_sum_o;
  logic                      block_end_o;

  // Stimulus and scoreboard
  logic signed [SampleW-1:0] pending_samples[$];
  sum_beat_t                 sums_due[$];
  int unsigned               send_idle_pct = 28;
  int unsigned               recv_idle_pct = 85;
  int unsigned               beats_in = 0;
  int unsigned               mismatches = 0;
  int unsigned               hold_left = 0;
  bit                        long_hold_done = 1'b0;

  // Model state: register mirror, column sums, counters
  logic [LenW-1:0]           len_mirror = LenW'(1);
  logic [StrideW-1:0]        stride_mirror = StrideW'(1);
  logic signed [SumW-1:0]    column_sum[DepthMax];
  int unsigned               col_idx = 0;
  int unsigned               row_idx = 0;

  strided_axis_prefix_sum_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .running_sum_o (running_sum_o),
    .block_end_o   (block_end_o)
  );

  // Clock and reset
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Advance the column-sum model by one accepted sample
  function automatic void accumulate_sample(input logic signed [SampleW-1:0] x);
    int unsigned rows;
    int unsigned cols;
    longint      acc;
    sum_beat_t   beat;
    rows = (len_mirror == '0) ? 1 : int'(len_mirror);
    cols = (stride_mirror == '0) ? 1 : int'(stride_mirror);
    if (cols > DepthMax) cols = DepthMax;
    if (col_idx >= cols) col_idx = 0;
    if (row_idx >= rows) row_idx = 0;
    if (row_idx == 0) acc = longint'(x);
    else acc = longint'(column_sum[col_idx]) + longint'(x);
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    column_sum[col_idx] = acc[SumW-1:0];
    beat.sum  = acc[SumW-1:0];
    beat.last = (col_idx + 1 == cols) && (row_idx + 1 == rows);
    sums_due.push_back(beat);
    col_idx++;
    if (col_idx >= cols) begin
      col_idx = 0;
      row_idx++;
      if (row_idx >= rows) row_idx = 0;
    end
  endfunction

  // Driver: offer pending samples, predict on acceptance
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        accumulate_sample(sample_i);
        beats_in++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          sample_i   <= pending_samples.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check output beats, random back-pressure plus one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (sums_due.size() == 0) begin
          $display("%0t: output beat with nothing expected: sum %0d end %0b",
                   $time, running_sum_o, block_end_o);
          mismatches++;
        end else begin
          if (running_sum_o !== sums_due[0].sum) begin
            $display("%0t: running_sum expected %0d actual %0d",
                     $time, sums_due[0].sum, running_sum_o);
            mismatches++;
          end
          if (block_end_o !== sums_due[0].last) begin
            $display("%0t: block_end expected %0b actual %0b",
                     $time, sums_due[0].last, block_end_o);
            mismatches++;
          end
          void'(sums_due.pop_front());
        end
      end
      if (!long_hold_done && beats_in >= 60 && pending_samples.size() > 20) begin
        long_hold_done = 1'b1;
        hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // APB transfer: setup cycle, access cycle, completes when pready is high
  task automatic apb_access(input logic wr, input logic [ApbAddrW-1:0] addr,
                            input logic [ApbDataW-1:0] wdata,
                            output logic [ApbDataW-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    rdata = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_reg(input logic [ApbAddrW-1:0] addr, input logic [ApbDataW-1:0] want);
    logic [ApbDataW-1:0] got;
    apb_access(1'b0, addr, '0, got);
    if (got !== want) begin
      $display("%0t: register 0x%0h expected %0d actual %0d", $time, addr, want, got);
      mismatches++;
    end
  endtask

  task automatic write_length(input logic [LenW-1:0] len);
    logic [ApbDataW-1:0] unused;
    apb_access(1'b1, AddrAxisLength, ApbDataW'(len), unused);
    len_mirror = len;
    col_idx = 0;
    row_idx = 0;
  endtask

  task automatic write_stride(input logic [StrideW-1:0] strd);
    logic [ApbDataW-1:0] unused;
    apb_access(1'b1, AddrInnerStride, ApbDataW'(strd), unused);
    stride_mirror = strd;
    col_idx = 0;
    row_idx = 0;
  endtask

  // Set the axis shape and read both registers back
  task automatic set_shape(input logic [LenW-1:0] len, input logic [StrideW-1:0] strd);
    write_length(len);
    write_stride(strd);
    check_reg(AddrAxisLength, ApbDataW'(len));
    check_reg(AddrInnerStride, ApbDataW'(strd));
  endtask

  // Wait until every sample is accepted and every sum has come out
  task automatic drain();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || in_valid_i || sums_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly full-range random samples, some extremes
  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh7fff;
      1:       return -16'sh8000;
      2:       return $urandom_range(0, 1) ? 16'sh0000 : -16'sh0001;
      default: return SampleW'($urandom);
    endcase
  endfunction

  task automatic run_random(input logic [LenW-1:0] len, input logic [StrideW-1:0] strd,
                            input int unsigned n);
    set_shape(len, strd);
    repeat (n) pending_samples.push_back(pick_sample());
    drain();
  endtask

  // Run time limit
  initial begin
    #5ms;
    $display("** strided_axis_prefix_sum_core: FAILED **");
    $finish;
  end

  // Test sequence
  initial begin
    @(posedge rst_ni);
    repeat (2) @(posedge clk_i);

    // Reset values: every sample is its own slice
    check_reg(AddrAxisLength, ApbDataW'(1));
    check_reg(AddrInnerStride, ApbDataW'(1));
    pending_samples = '{16'sh7fff, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001};
    drain();

    // Extremes accumulating over three rows of two, then a fresh slice
    set_shape(LenW'(3), StrideW'(2));
    pending_samples = '{16'sh7fff, -16'sh8000, 16'sh7fff, -16'sh8000,
                        16'sh7fff, -16'sh8000, 16'sh0100, -16'sh0100};
    drain();

    // Register write in mid-slice restarts at row 0
    set_shape(LenW'(3), StrideW'(2));
    pending_samples = '{16'sh1234, -16'sh0777, 16'sh0042, 16'sh7fff, -16'sh0001};
    drain();
    write_length(LenW'(3));
    pending_samples = '{16'sh0005, -16'sh0009};
    drain();

    // Zero length and zero stride behave as one
    set_shape(LenW'(0), StrideW'(0));
    pending_samples = '{-16'sh8000, 16'sh7fff, 16'sh0003};
    drain();

    // Random traffic, sender light gaps and receiver heavy stalls
    send_idle_pct = 28;
    recv_idle_pct = 85;
    run_random(LenW'(4), StrideW'(3), 200);
    run_random(LenW'(65535), StrideW'(1024), 100);
    run_random(LenW'(0), StrideW'(5), 100);

    // Swapped: sparse sender, mostly ready receiver; stride clamps to depth
    send_idle_pct = 85;
    recv_idle_pct = 28;
    run_random(LenW'(2), StrideW'(2047), 1100);
    run_random(LenW'(5), StrideW'(0), 100);

    // Back to back in both directions
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(LenW'($urandom_range(1, 8)), StrideW'($urandom_range(1, 12)), 150);
    run_random(LenW'($urandom_range(1, 8)), StrideW'($urandom_range(1, 12)), 150);
    run_random(LenW'(1), StrideW'(1), 100);

    // Catch any stray beat after the last expected one
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && sums_due.size() == 0) begin
      $display("** strided_axis_prefix_sum_core: PASSED **");
    end else begin
      $display("** strided_axis_prefix_sum_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/sps_pkg.sv
rtl/sps_cfg_regs.sv
rtl/sps_addr_gen.sv
rtl/sps_accum.sv
rtl/strided_axis_prefix_sum_core.sv
tb/sv/testbench.sv
